// ===== src/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types, constants and the divider step for the ray/box slab core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbsi_pkg;

    localparam int AXES           = 3;
    localparam int LANES          = 2 * AXES;   // low face and high face per axis
    localparam int DIV_BITS       = 32;         // quotient bits below the overflow check
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;

    // Distances widened by two bits so the unbounded slab ends sit outside
    // the saturated range.
    localparam logic signed [33:0] T_NEG_INF = -34'sd4294967296;
    localparam logic signed [33:0] T_POS_INF = 34'sd4294967296;
    localparam logic signed [31:0] T_SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] box_low_x;
        logic signed [31:0] box_low_y;
        logic signed [31:0] box_low_z;
        logic        [30:0] box_size_x;
        logic        [30:0] box_size_y;
        logic        [30:0] box_size_z;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               started_inside;
    } t_out;

    // One restoring-division lane: partial remainder, dividend bits still to
    // shift in, quotient built so far, divisor magnitude.
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [15:0] den;
    } t_lane;

    // Per-item data that rides alongside the divider lanes.
    typedef struct packed {
        logic [AXES-1:0][31:0] org;
        logic [AXES-1:0][15:0] dir;
        logic [LANES-1:0]      neg;
        logic [LANES-1:0]      ovf;
        logic [AXES-1:0]       dz;
        logic [AXES-1:0]       in_slab;
    } t_side;

    // Retire BITS_PER_STAGE quotient bits.
    function automatic t_lane div_step(input t_lane l);
        t_lane       r;
        logic [16:0] trial;
        r = l;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            trial = {r.rem, r.num[31]};
            r.num = {r.num[30:0], 1'b0};
            if (trial >= {1'b0, r.den}) begin
                r.rem = 16'(trial - {1'b0, r.den});
                r.quo = {r.quo[30:0], 1'b1};
            end else begin
                r.rem = trial[15:0];
                r.quo = {r.quo[30:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== src/rbsi_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// Six-lane pipelined restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_div_pipe (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_vld,
    input  rbsi_pkg::t_lane [rbsi_pkg::LANES-1:0]  i_lane,
    input  rbsi_pkg::t_side                        i_side,
    output logic                                   o_vld,
    output logic [rbsi_pkg::LANES-1:0][31:0]       o_quo,
    output rbsi_pkg::t_side                        o_side
);

    rbsi_pkg::t_lane [rbsi_pkg::LANES-1:0] r_lane [rbsi_pkg::DIV_STAGES];
    rbsi_pkg::t_side                       r_side [rbsi_pkg::DIV_STAGES];
    logic [rbsi_pkg::DIV_STAGES-1:0]       r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[rbsi_pkg::DIV_STAGES-2:0], i_vld};
        end
    end

    // First stage takes the prepared lanes.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                r_lane[0][l] <= rbsi_pkg::div_step(i_lane[l]);
            end
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s < rbsi_pkg::DIV_STAGES; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                    r_lane[s][l] <= rbsi_pkg::div_step(r_lane[s-1][l]);
                end
                r_side[s] <= r_side[s-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < rbsi_pkg::LANES; l++) begin
            o_quo[l] = r_lane[rbsi_pkg::DIV_STAGES-1][l].quo;
        end
    end

    assign o_vld  = r_vld[rbsi_pkg::DIV_STAGES-1];
    assign o_side = r_side[rbsi_pkg::DIV_STAGES-1];

endmodule

// ===== src/ray_box_slab_intersection_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_core
// Slab test of one ray against one axis-aligned box per transfer. Each item
// flows through 18 register stages: input capture, face offsets, slab
// bounds, divisor setup, eight divider stages of four quotient bits, distance
// saturation, per-axis near/far, tmin/tmax, hit decision, entry-point
// multiply and the output register. A new transfer is taken every cycle
// unless the output stalls: when the output register is full and the
// downstream i_ready is low, the whole pipe holds in place, so nothing
// is lost or repeated. Zero direction components give an unbounded slab
// when the origin lies between the faces (inclusive), else a miss.
// Distances are Q16.15 and saturate to 32 bits; the entry point is origin
// plus dir*tmin floored to the origin's units, saturated to 32 bits, or
// the origin itself when the ray starts inside the box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_box_slab_intersection_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rbsi_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output rbsi_pkg::t_out  o_data
);

    localparam int AXES  = rbsi_pkg::AXES;
    localparam int LANES = rbsi_pkg::LANES;

    // Global advance: every stage moves when the output slot is free or
    // being drained this cycle.
    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // ---------------- stage 1: capture ----------------
    logic          r1_vld;
    rbsi_pkg::t_in r1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1 <= i_data;
        end
    end

    logic [AXES-1:0][31:0] w_org;
    logic [AXES-1:0][15:0] w_dir;
    logic [AXES-1:0][31:0] w_low;
    logic [AXES-1:0][30:0] w_size;

    always_comb begin
        w_org  = {r1.origin_z, r1.origin_y, r1.origin_x};
        w_dir  = {r1.dir_z, r1.dir_y, r1.dir_x};
        w_low  = {r1.box_low_z, r1.box_low_y, r1.box_low_x};
        w_size = {r1.box_size_z, r1.box_size_y, r1.box_size_x};
    end

    // ---------------- stage 2: low-face offset ----------------
    logic                  r2_vld;
    logic [AXES-1:0][34:0] r2_dlo;
    logic [AXES-1:0][30:0] r2_size;
    logic [AXES-1:0][31:0] r2_org;
    logic [AXES-1:0][15:0] r2_dir;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < AXES; a++) begin
                r2_dlo[a] <= {{3{w_low[a][31]}}, w_low[a]} - {{3{w_org[a][31]}}, w_org[a]};
            end
            r2_size <= w_size;
            r2_org  <= w_org;
            r2_dir  <= w_dir;
        end
    end

    // ---------------- stage 3: high-face offset, slab membership ----------------
    logic                  r3_vld;
    logic [AXES-1:0][34:0] r3_dlo;
    logic [AXES-1:0][34:0] r3_dhi;
    logic [AXES-1:0]       r3_inside;
    logic [AXES-1:0][31:0] r3_org;
    logic [AXES-1:0][15:0] r3_dir;
    logic [AXES-1:0][34:0] w_dhi;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_dhi[a] = r2_dlo[a] + {4'b0, r2_size[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < AXES; a++) begin
                // origin between the faces: low - org <= 0 and high - org >= 0
                r3_inside[a] <= ($signed(r2_dlo[a]) <= 35'sd0) && !w_dhi[a][34];
            end
            r3_dlo <= r2_dlo;
            r3_dhi <= w_dhi;
            r3_org <= r2_org;
            r3_dir <= r2_dir;
        end
    end

    // ---------------- stage 4: divisor setup ----------------
    logic                                r4_vld;
    rbsi_pkg::t_lane [LANES-1:0]         r4_lane;
    rbsi_pkg::t_side                     r4_side;
    logic [LANES-1:0][34:0]              w_d;
    logic [LANES-1:0][32:0]              w_mag;
    logic [LANES-1:0][15:0]              w_den;
    logic [LANES-1:0][15:0]              w_dirl;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_d[2*a]      = r3_dlo[a];
            w_d[2*a+1]    = r3_dhi[a];
            w_dirl[2*a]   = r3_dir[a];
            w_dirl[2*a+1] = r3_dir[a];
        end
        for (int l = 0; l < LANES; l++) begin
            w_mag[l] = w_d[l][34] ? 33'(-w_d[l]) : w_d[l][32:0];
            w_den[l] = w_dirl[l][15] ? 16'(-w_dirl[l]) : w_dirl[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < LANES; l++) begin
                // dividend is |d| << 15; top 16 bits seed the remainder
                r4_lane[l].rem   <= w_mag[l][32:17];
                r4_lane[l].num   <= {w_mag[l][16:0], 15'b0};
                r4_lane[l].quo   <= '0;
                r4_lane[l].den   <= w_den[l];
                r4_side.neg[l]   <= w_d[l][34] ^ w_dirl[l][15];
                r4_side.ovf[l]   <= w_mag[l][32:17] >= w_den[l];
            end
            for (int a = 0; a < AXES; a++) begin
                r4_side.dz[a] <= (r3_dir[a] == 16'd0);
            end
            r4_side.in_slab <= r3_inside;
            r4_side.org     <= r3_org;
            r4_side.dir     <= r3_dir;
        end
    end

    // ---------------- stages 5..12: divider ----------------
    logic                   w_dv_vld;
    logic [LANES-1:0][31:0] w_quo;
    rbsi_pkg::t_side        w_dv_side;

    rbsi_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r4_vld),
        .i_lane  (r4_lane),
        .i_side  (r4_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // ---------------- stage 13: signed, saturated distances ----------------
    logic                   r13_vld;
    logic [LANES-1:0][31:0] r13_t;
    rbsi_pkg::t_side        r13_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < LANES; l++) begin
                if (w_dv_side.neg[l]) begin
                    if (w_dv_side.ovf[l] || (w_quo[l][31] && (w_quo[l][30:0] != '0))) begin
                        r13_t[l] <= rbsi_pkg::T_SAT_MIN;
                    end else begin
                        r13_t[l] <= 32'(-w_quo[l]);
                    end
                end else begin
                    if (w_dv_side.ovf[l] || w_quo[l][31]) begin
                        r13_t[l] <= rbsi_pkg::T_SAT_MAX;
                    end else begin
                        r13_t[l] <= w_quo[l];
                    end
                end
            end
            r13_side <= w_dv_side;
        end
    end

    // ---------------- stage 14: per-axis entry and exit ----------------
    logic                  r14_vld;
    logic [AXES-1:0][33:0] r14_near;
    logic [AXES-1:0][33:0] r14_far;
    logic [AXES-1:0]       r14_ok;
    logic [AXES-1:0][31:0] r14_org;
    logic [AXES-1:0][15:0] r14_dir;
    logic [AXES-1:0][33:0] w_ta;
    logic [AXES-1:0][33:0] w_tb;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_ta[a] = {{2{r13_t[2*a][31]}}, r13_t[2*a]};
            w_tb[a] = {{2{r13_t[2*a+1][31]}}, r13_t[2*a+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < AXES; a++) begin
                if (r13_side.dz[a]) begin
                    r14_ok[a]   <= r13_side.in_slab[a];
                    r14_near[a] <= rbsi_pkg::T_NEG_INF;
                    r14_far[a]  <= rbsi_pkg::T_POS_INF;
                end else begin
                    r14_ok[a] <= 1'b1;
                    if ($signed(w_ta[a]) < $signed(w_tb[a])) begin
                        r14_near[a] <= w_ta[a];
                        r14_far[a]  <= w_tb[a];
                    end else begin
                        r14_near[a] <= w_tb[a];
                        r14_far[a]  <= w_ta[a];
                    end
                end
            end
            r14_org <= r13_side.org;
            r14_dir <= r13_side.dir;
        end
    end

    // ---------------- stage 15: tmin / tmax ----------------
    logic                  r15_vld;
    logic signed [33:0]    r15_tmin;
    logic signed [33:0]    r15_tmax;
    logic                  r15_ok;
    logic [AXES-1:0][31:0] r15_org;
    logic [AXES-1:0][15:0] r15_dir;
    logic signed [33:0]    w_tmin;
    logic signed [33:0]    w_tmax;

    always_comb begin
        w_tmin = rbsi_pkg::T_NEG_INF;
        w_tmax = rbsi_pkg::T_POS_INF;
        for (int a = 0; a < AXES; a++) begin
            if ($signed(r14_near[a]) > w_tmin) begin
                w_tmin = r14_near[a];
            end
            if ($signed(r14_far[a]) < w_tmax) begin
                w_tmax = r14_far[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r15_tmin <= w_tmin;
            r15_tmax <= w_tmax;
            r15_ok   <= &r14_ok;
            r15_org  <= r14_org;
            r15_dir  <= r14_dir;
        end
    end

    // ---------------- stage 16: hit decision ----------------
    logic                  r16_vld;
    logic                  r16_hit;
    logic                  r16_inside;
    logic [31:0]           r16_tmin;
    logic [AXES-1:0][31:0] r16_org;
    logic [AXES-1:0][15:0] r16_dir;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r16_hit    <= r15_ok && !r15_tmax[33] && !(r15_tmin > r15_tmax);
            r16_inside <= r15_tmin[33];
            r16_tmin   <= r15_tmin[31:0];
            r16_org    <= r15_org;
            r16_dir    <= r15_dir;
        end
    end

    // ---------------- stage 17: dir * tmin ----------------
    logic                  r17_vld;
    logic                  r17_hit;
    logic                  r17_inside;
    logic [AXES-1:0][47:0] r17_prod;
    logic [AXES-1:0][31:0] r17_org;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < AXES; a++) begin
                // tmin is non-negative and finite whenever the product is used
                r17_prod[a] <= 48'($signed(r16_dir[a]) * $signed(r16_tmin));
            end
            r17_hit    <= r16_hit;
            r17_inside <= r16_inside;
            r17_org    <= r16_org;
        end
    end

    // ---------------- stage 18: entry point, output register ----------------
    logic [AXES-1:0][33:0] w_sum;
    logic [AXES-1:0][31:0] w_pt;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            // arithmetic shift floors toward minus infinity
            w_sum[a] = {{2{r17_org[a][31]}}, r17_org[a]} + {r17_prod[a][47], r17_prod[a][47:15]};
            if (!w_sum[a][33] && (w_sum[a][32:31] != 2'b00)) begin
                w_pt[a] = rbsi_pkg::T_SAT_MAX;
            end else if (w_sum[a][33] && (w_sum[a][32:31] != 2'b11)) begin
                w_pt[a] = rbsi_pkg::T_SAT_MIN;
            end else begin
                w_pt[a] = w_sum[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (!r17_hit) begin
                o_data <= '0;
            end else if (r17_inside) begin
                o_data.hit            <= 1'b1;
                o_data.point_x        <= r17_org[0];
                o_data.point_y        <= r17_org[1];
                o_data.point_z        <= r17_org[2];
                o_data.started_inside <= 1'b1;
            end else begin
                o_data.hit            <= 1'b1;
                o_data.point_x        <= w_pt[0];
                o_data.point_y        <= w_pt[1];
                o_data.point_z        <= w_pt[2];
                o_data.started_inside <= 1'b0;
            end
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r13_vld <= 1'b0;
            r14_vld <= 1'b0;
            r15_vld <= 1'b0;
            r16_vld <= 1'b0;
            r17_vld <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r13_vld <= w_dv_vld;
            r14_vld <= r13_vld;
            r15_vld <= r14_vld;
            r16_vld <= r15_vld;
            r17_vld <= r16_vld;
            o_valid <= r17_vld;
        end
    end

endmodule

// ===== src/rbsi_checker.sv =====
// ----------------------------------------------------------------------------
// rbsi_checker
// Port-level checks for the ray/box slab core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input rbsi_pkg::t_in   i_data,
    input logic            o_valid,
    input logic            i_ready,
    input rbsi_pkg::t_out  o_data
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // A miss carries no point and no inside flag.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.hit |-> o_data.point_x == 0 && o_data.point_y == 0
            && o_data.point_z == 0 && !o_data.started_inside)
        else $error("miss with nonzero payload");

    // Started inside only on a hit.
    a_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.started_inside |-> o_data.hit)
        else $error("started_inside without hit");

    // Accept whenever the output slot is empty.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind ray_box_slab_intersection_core rbsi_checker u_rbsi_checker (.*);
